// ----- rtl/etok_pkg.sv -----
// Package for the expression tokenizer: token kinds, scanner modes, token record
// and small character-class and reserved-word helpers. No dependencies.
`default_nettype none
package etok_pkg;

    localparam int unsigned POS_W     = 16;
    localparam int unsigned VAL_W     = 31;
    localparam int unsigned FRAC_W    = 5;
    localparam int unsigned KIND_W    = 6;
    localparam int unsigned NUM_RW    = 6;
    localparam int unsigned MAX_RES   = 3;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [VAL_W-1:0] SAT_VAL = {VAL_W{1'b1}};
    localparam logic [FRAC_W-1:0] FRAC_MAX = {FRAC_W{1'b1}};
    localparam logic [3:0] WLEN_MAX  = 4'd15;

    // token kinds
    localparam logic [KIND_W-1:0] K_END    = 6'd0;
    localparam logic [KIND_W-1:0] K_ERR    = 6'd1;
    localparam logic [KIND_W-1:0] K_INT    = 6'd2;
    localparam logic [KIND_W-1:0] K_REAL   = 6'd3;
    localparam logic [KIND_W-1:0] K_STR    = 6'd4;
    localparam logic [KIND_W-1:0] K_UNDEF  = 6'd5;
    localparam logic [KIND_W-1:0] K_ERRLIT = 6'd6;
    localparam logic [KIND_W-1:0] K_IDENT  = 6'd7;
    localparam logic [KIND_W-1:0] K_DOT    = 6'd8;
    localparam logic [KIND_W-1:0] K_MUL    = 6'd9;
    localparam logic [KIND_W-1:0] K_DIV    = 6'd10;
    localparam logic [KIND_W-1:0] K_MOD    = 6'd11;
    localparam logic [KIND_W-1:0] K_ADD    = 6'd12;
    localparam logic [KIND_W-1:0] K_SUB    = 6'd13;
    localparam logic [KIND_W-1:0] K_TILDE  = 6'd14;
    localparam logic [KIND_W-1:0] K_CARET  = 6'd15;
    localparam logic [KIND_W-1:0] K_QUEST  = 6'd16;
    localparam logic [KIND_W-1:0] K_COLON  = 6'd17;
    localparam logic [KIND_W-1:0] K_SEMI   = 6'd18;
    localparam logic [KIND_W-1:0] K_COMMA  = 6'd19;
    localparam logic [KIND_W-1:0] K_LBRK   = 6'd20;
    localparam logic [KIND_W-1:0] K_RBRK   = 6'd21;
    localparam logic [KIND_W-1:0] K_LPAR   = 6'd22;
    localparam logic [KIND_W-1:0] K_RPAR   = 6'd23;
    localparam logic [KIND_W-1:0] K_LBRC   = 6'd24;
    localparam logic [KIND_W-1:0] K_RBRC   = 6'd25;
    localparam logic [KIND_W-1:0] K_AMP    = 6'd26;
    localparam logic [KIND_W-1:0] K_LAND   = 6'd27;
    localparam logic [KIND_W-1:0] K_BAR    = 6'd28;
    localparam logic [KIND_W-1:0] K_LOR    = 6'd29;
    localparam logic [KIND_W-1:0] K_LT     = 6'd30;
    localparam logic [KIND_W-1:0] K_LE     = 6'd31;
    localparam logic [KIND_W-1:0] K_SHL    = 6'd32;
    localparam logic [KIND_W-1:0] K_GT     = 6'd33;
    localparam logic [KIND_W-1:0] K_GE     = 6'd34;
    localparam logic [KIND_W-1:0] K_SHR    = 6'd35;
    localparam logic [KIND_W-1:0] K_SHRU   = 6'd36;
    localparam logic [KIND_W-1:0] K_ASSIGN = 6'd37;
    localparam logic [KIND_W-1:0] K_EQ     = 6'd38;
    localparam logic [KIND_W-1:0] K_META_EQ = 6'd39;
    localparam logic [KIND_W-1:0] K_META_NE = 6'd40;
    localparam logic [KIND_W-1:0] K_NOT    = 6'd41;
    localparam logic [KIND_W-1:0] K_NE     = 6'd42;

    typedef enum logic [14:0] {
        MODE_IDLE   = 15'h0001,
        MODE_INT    = 15'h0002,
        MODE_FRAC   = 15'h0004,
        MODE_WORD   = 15'h0008,
        MODE_IDENT  = 15'h0010,
        MODE_STR    = 15'h0020,
        MODE_AMP    = 15'h0040,
        MODE_BAR    = 15'h0080,
        MODE_LT     = 15'h0100,
        MODE_GT     = 15'h0200,
        MODE_GTGT   = 15'h0400,
        MODE_EQ     = 15'h0800,
        MODE_EQQ    = 15'h1000,
        MODE_EQBANG = 15'h2000,
        MODE_BANG   = 15'h4000
    } mode_t;

    typedef struct packed {
        logic [15:0]       len;
        logic [15:0]       start;
        logic              ovf;
        logic [1:0]        fac;
        logic [FRAC_W-1:0] frac;
        logic [VAL_W-1:0]  value;
        logic [KIND_W-1:0] kind;
    } token_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic [7:0] to_lower(logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
    endfunction

    function automatic logic [1:0] factor_of(logic [7:0] c);
        logic [7:0] l;
        begin
            l = to_lower(c);
            if (l == "k")
                return 2'd1;
            else if (l == "m")
                return 2'd2;
            else if (l == "g")
                return 2'd3;
            return 2'd0;
        end
    endfunction

    function automatic logic [KIND_W-1:0] single_op(logic [7:0] c);
        logic [KIND_W-1:0] k;
        begin
            unique case (c)
                ".":     k = K_DOT;
                "*":     k = K_MUL;
                "/":     k = K_DIV;
                "%":     k = K_MOD;
                "+":     k = K_ADD;
                "-":     k = K_SUB;
                "~":     k = K_TILDE;
                "^":     k = K_CARET;
                "?":     k = K_QUEST;
                ":":     k = K_COLON;
                ";":     k = K_SEMI;
                ",":     k = K_COMMA;
                "[":     k = K_LBRK;
                "]":     k = K_RBRK;
                "(":     k = K_LPAR;
                ")":     k = K_RPAR;
                "{":     k = K_LBRC;
                "}":     k = K_RBRC;
                default: k = K_END;
            endcase
            return k;
        end
    endfunction

    function automatic logic [3:0] rw_len(int unsigned k);
        logic [3:0] r;
        begin
            unique case (k)
                0:       r = 4'd4;
                1:       r = 4'd5;
                2:       r = 4'd9;
                3:       r = 4'd5;
                4:       r = 4'd2;
                default: r = 4'd4;
            endcase
            return r;
        end
    endfunction

    function automatic logic [KIND_W-1:0] rw_kind(int unsigned k);
        logic [KIND_W-1:0] r;
        begin
            unique case (k)
                0, 1:    r = K_INT;
                2:       r = K_UNDEF;
                3:       r = K_ERRLIT;
                4:       r = K_META_EQ;
                default: r = K_META_NE;
            endcase
            return r;
        end
    endfunction

    // character i of reserved word k, zero past its end
    function automatic logic [7:0] rw_char(int unsigned k, logic [3:0] i);
        logic [71:0] w;
        logic [3:0]  len;
        logic [3:0]  sh;
        begin
            unique case (k)
                0:       w = 72'("true");
                1:       w = 72'("false");
                2:       w = 72'("undefined");
                3:       w = 72'("error");
                4:       w = 72'("is");
                default: w = 72'("isnt");
            endcase
            len = rw_len(k);
            sh  = len - 4'd1 - i;
            if (i >= len)
                return 8'd0;
            return w[{sh, 3'b000} +: 8];
        end
    endfunction

    function automatic token_t make_kind(logic [KIND_W-1:0] k);
        token_t t;
        begin
            t      = '0;
            t.kind = k;
            return t;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/expression_tokenizer_unit.sv -----
// Expression tokenizer top level: byte-stream lexer with a three-entry token queue.
// Depends on etok_pkg.
//
// Timing: a token caused by an input byte appears on the master side in the cycle
// after the byte is accepted. Throughput: one byte per cycle while each byte gives
// at most one token and the master side is ready; a byte that gives more tokens holds
// the input while the single output port drains the token queue.
// Reset: scanner idle at offset 0, queue empty, reserved-word case folding on.
`default_nettype none
module expression_tokenizer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,      // reserved_ignore_case
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,        // [7:0] text_byte
    input  wire logic        s_tlast,        // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [5:0] token_kind, [36:6] number_value, [41:37] fraction_digits,
    // [43:42] size_factor, [44] value_overflow, [60:45] text_start,
    // [76:61] text_length, [79:77] zero
    output logic [79:0]      m_tdata,
    output logic             m_tlast         // last_of_run
);
    import etok_pkg::*;

    // configuration
    logic ignore_case_reg;

    // scanner state
    mode_t              mode_reg,  mode_next;
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [POS_W-1:0]   tbeg_reg,  tbeg_next;
    logic [VAL_W-1:0]   mant_reg,  mant_next;
    logic [FRAC_W-1:0]  fcnt_reg,  fcnt_next;
    logic               sat_reg,   sat_next;
    logic [NUM_RW-1:0]  cand_reg,  cand_next;
    logic [3:0]         wlen_reg,  wlen_next;
    logic               fin_reg,   fin_next;

    // token queue: entry 0 is the head shown on the master side
    token_t             q_reg   [MAX_RES];
    logic [MAX_RES-1:0] qlast_reg;
    logic [1:0]         qcnt_reg;

    // results of the byte being accepted
    token_t             res     [MAX_RES];
    logic [1:0]         nres;

    logic [7:0]         c;
    logic               last_in;
    logic               accept;
    logic               pop;

    assign c       = s_tdata;
    assign last_in = s_tlast;
    assign pop     = m_tvalid && m_tready;
    // take a new byte once the queue is empty or its last token leaves now
    assign s_tready = (qcnt_reg == 2'd0) || ((qcnt_reg == 2'd1) && m_tready);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = (qcnt_reg != 2'd0);
    assign m_tdata  = {3'b000, q_reg[0]};
    assign m_tlast  = qlast_reg[0];

    // One byte of scanning: close the pending token, start a new one, and
    // at end of text flush and add the end token.
    always_comb
    begin : scan
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] np;
        logic [POS_W-1:0] endpos;
        logic             used;
        logic [34:0]      prod;
        logic [7:0]       lc;
        token_t           t;

        mode_next = mode_reg;
        pos_next  = pos_reg;
        tbeg_next = tbeg_reg;
        mant_next = mant_reg;
        fcnt_next = fcnt_reg;
        sat_next  = sat_reg;
        cand_next = cand_reg;
        wlen_next = wlen_reg;
        fin_next  = fin_reg;
        nres      = 2'd0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            res[i] = '0;
        end
        p        = pos_reg;
        np       = (pos_reg != POS_MAX) ? pos_reg + 1'b1 : pos_reg;
        endpos   = p;
        used     = 1'b0;
        prod     = '0;
        lc       = 8'd0;
        t        = '0;

        if (fin_reg)
        begin
            // drop the rest of the text; restart on its last byte
            if (last_in)
            begin
                mode_next = MODE_IDLE;
                pos_next  = '0;
                tbeg_next = '0;
                mant_next = '0;
                fcnt_next = '0;
                sat_next  = 1'b0;
                cand_next = '1;
                wlen_next = 4'd0;
                fin_next  = 1'b0;
            end
        end
        else
        begin
            if (c != 8'd0)
            begin
                // continue the pending token
                mode_next = MODE_IDLE;
                unique case (mode_reg)
                    MODE_IDLE:
                    begin
                        used = 1'b0;
                    end
                    MODE_INT, MODE_FRAC:
                    begin
                        if (is_digit(c))
                        begin
                            used      = 1'b1;
                            mode_next = mode_reg;
                            if ((mode_reg == MODE_INT) || (fcnt_reg != FRAC_MAX))
                            begin
                                prod = {4'd0, mant_reg} * 35'd10 + 35'(c - "0");
                                if (prod > 35'(SAT_VAL))
                                begin
                                    mant_next = SAT_VAL;
                                    sat_next  = 1'b1;
                                end
                                else
                                begin
                                    mant_next = prod[VAL_W-1:0];
                                end
                                if (mode_reg == MODE_FRAC)
                                    fcnt_next = fcnt_reg + 1'b1;
                            end
                        end
                        else if ((c == ".") && (mode_reg == MODE_INT))
                        begin
                            used      = 1'b1;
                            mode_next = MODE_FRAC;
                        end
                        else
                        begin
                            used    = (factor_of(c) != 2'd0);
                            t       = '0;
                            t.kind  = (mode_reg == MODE_FRAC) ? K_REAL : K_INT;
                            t.value = mant_reg;
                            t.frac  = (mode_reg == MODE_FRAC) ? fcnt_reg : '0;
                            t.fac   = factor_of(c);
                            t.ovf   = sat_reg;
                            res[nres] = t;
                            nres = nres + 2'd1;
                        end
                    end
                    MODE_WORD:
                    begin
                        if (is_alpha(c))
                        begin
                            used      = 1'b1;
                            mode_next = MODE_WORD;
                            lc = ignore_case_reg ? to_lower(c) : c;
                            for (int k = 0; k < NUM_RW; k++)
                            begin
                                if (!((wlen_reg < rw_len(k)) && (rw_char(k, wlen_reg) == lc)))
                                    cand_next[k] = 1'b0;
                            end
                            if (wlen_reg != WLEN_MAX)
                                wlen_next = wlen_reg + 1'b1;
                        end
                        else if (is_digit(c) || (c == "_"))
                        begin
                            used      = 1'b1;
                            mode_next = MODE_IDENT;
                        end
                        else
                        begin
                            t        = make_kind(K_IDENT);
                            t.start  = tbeg_reg;
                            t.len    = p - tbeg_reg;
                            for (int k = NUM_RW - 1; k >= 0; k--)
                            begin
                                if (cand_reg[k] && (wlen_reg == rw_len(k)))
                                begin
                                    t        = make_kind(rw_kind(k));
                                    t.value  = (k == 0) ? VAL_W'(1) : '0;
                                end
                            end
                            res[nres] = t;
                            nres = nres + 2'd1;
                        end
                    end
                    MODE_IDENT:
                    begin
                        if (is_alpha(c) || is_digit(c) || (c == "_"))
                        begin
                            used      = 1'b1;
                            mode_next = MODE_IDENT;
                        end
                        else
                        begin
                            t       = make_kind(K_IDENT);
                            t.start = tbeg_reg;
                            t.len   = p - tbeg_reg;
                            res[nres] = t;
                            nres = nres + 2'd1;
                        end
                    end
                    MODE_STR:
                    begin
                        used = 1'b1;
                        if (c == "\"")
                        begin
                            t       = make_kind(K_STR);
                            t.start = tbeg_reg;
                            t.len   = p - tbeg_reg;
                            res[nres] = t;
                            nres = nres + 2'd1;
                        end
                        else
                        begin
                            mode_next = MODE_STR;
                        end
                    end
                    MODE_AMP:
                    begin
                        used = (c == "&");
                        res[nres] = make_kind(used ? K_LAND : K_AMP);
                        nres = nres + 2'd1;
                    end
                    MODE_BAR:
                    begin
                        used = (c == "|");
                        res[nres] = make_kind(used ? K_LOR : K_BAR);
                        nres = nres + 2'd1;
                    end
                    MODE_LT:
                    begin
                        used = (c == "=") || (c == "<");
                        res[nres] = make_kind((c == "=") ? K_LE : ((c == "<") ? K_SHL : K_LT));
                        nres = nres + 2'd1;
                    end
                    MODE_GT:
                    begin
                        if (c == ">")
                        begin
                            used      = 1'b1;
                            mode_next = MODE_GTGT;
                        end
                        else
                        begin
                            used = (c == "=");
                            res[nres] = make_kind(used ? K_GE : K_GT);
                            nres = nres + 2'd1;
                        end
                    end
                    MODE_GTGT:
                    begin
                        used = (c == ">");
                        res[nres] = make_kind(used ? K_SHRU : K_SHR);
                        nres = nres + 2'd1;
                    end
                    MODE_EQ:
                    begin
                        if (c == "?")
                        begin
                            used      = 1'b1;
                            mode_next = MODE_EQQ;
                        end
                        else if (c == "!")
                        begin
                            used      = 1'b1;
                            mode_next = MODE_EQBANG;
                        end
                        else
                        begin
                            used = (c == "=");
                            res[nres] = make_kind(used ? K_EQ : K_ASSIGN);
                            nres = nres + 2'd1;
                        end
                    end
                    MODE_EQQ:
                    begin
                        used = (c == "=");
                        res[nres] = make_kind(used ? K_META_EQ : K_ERR);
                        nres = nres + 2'd1;
                    end
                    MODE_EQBANG:
                    begin
                        // the byte after =! is always consumed
                        used = 1'b1;
                        res[nres] = make_kind((c == "=") ? K_META_NE : K_ERR);
                        nres = nres + 2'd1;
                    end
                    MODE_BANG:
                    begin
                        used = (c == "=");
                        res[nres] = make_kind(used ? K_NE : K_NOT);
                        nres = nres + 2'd1;
                    end
                    default:
                    begin
                        used = 1'b0;
                    end
                endcase

                // start a new token with an unconsumed byte
                if (!used)
                begin
                    priority if (is_space(c))
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (is_digit(c))
                    begin
                        mant_next = VAL_W'(c - "0");
                        fcnt_next = '0;
                        sat_next  = 1'b0;
                        mode_next = MODE_INT;
                    end
                    else if (is_alpha(c))
                    begin
                        tbeg_next = p;
                        lc = ignore_case_reg ? to_lower(c) : c;
                        for (int k = 0; k < NUM_RW; k++)
                        begin
                            cand_next[k] = (rw_char(k, 4'd0) == lc);
                        end
                        wlen_next = 4'd1;
                        mode_next = MODE_WORD;
                    end
                    else if (c == "_")
                    begin
                        tbeg_next = p;
                        mode_next = MODE_IDENT;
                    end
                    else if (c == "\"")
                    begin
                        tbeg_next = np;
                        mode_next = MODE_STR;
                    end
                    else if (single_op(c) != K_END)
                    begin
                        res[nres] = make_kind(single_op(c));
                        nres = nres + 2'd1;
                    end
                    else if (c == "&")
                        mode_next = MODE_AMP;
                    else if (c == "|")
                        mode_next = MODE_BAR;
                    else if (c == "<")
                        mode_next = MODE_LT;
                    else if (c == ">")
                        mode_next = MODE_GT;
                    else if (c == "=")
                        mode_next = MODE_EQ;
                    else if (c == "!")
                        mode_next = MODE_BANG;
                    else
                    begin
                        res[nres] = make_kind(K_ERR);
                        nres = nres + 2'd1;
                    end
                end
            end

            if ((c == 8'd0) || last_in)
            begin
                // flush the pending token, then the end token, then restart
                endpos = (c == 8'd0) ? p : np;
                t = '0;
                unique case (mode_next)
                    MODE_IDLE:
                    begin
                        t = '0;
                    end
                    MODE_INT, MODE_FRAC:
                    begin
                        t.kind  = (mode_next == MODE_FRAC) ? K_REAL : K_INT;
                        t.value = mant_next;
                        t.frac  = (mode_next == MODE_FRAC) ? fcnt_next : '0;
                        t.ovf   = sat_next;
                    end
                    MODE_WORD, MODE_IDENT:
                    begin
                        t       = make_kind(K_IDENT);
                        t.start = tbeg_next;
                        t.len   = endpos - tbeg_next;
                        if (mode_next == MODE_WORD)
                        begin
                            for (int k = NUM_RW - 1; k >= 0; k--)
                            begin
                                if (cand_next[k] && (wlen_next == rw_len(k)))
                                begin
                                    t       = make_kind(rw_kind(k));
                                    t.value = (k == 0) ? VAL_W'(1) : '0;
                                end
                            end
                        end
                    end
                    MODE_AMP:    t = make_kind(K_AMP);
                    MODE_BAR:    t = make_kind(K_BAR);
                    MODE_LT:     t = make_kind(K_LT);
                    MODE_GT:     t = make_kind(K_GT);
                    MODE_GTGT:   t = make_kind(K_SHR);
                    MODE_EQ:     t = make_kind(K_ASSIGN);
                    MODE_BANG:   t = make_kind(K_NOT);
                    MODE_STR, MODE_EQQ, MODE_EQBANG:
                                 t = make_kind(K_ERR);
                    default:     t = '0;
                endcase
                if (mode_next != MODE_IDLE)
                begin
                    res[nres] = t;
                    nres = nres + 2'd1;
                end
                res[nres] = make_kind(K_END);
                nres = nres + 2'd1;

                mode_next = MODE_IDLE;
                pos_next  = '0;
                tbeg_next = '0;
                mant_next = '0;
                fcnt_next = '0;
                sat_next  = 1'b0;
                cand_next = '1;
                wlen_next = 4'd0;
                fin_next  = (c == 8'd0) && !last_in;
            end
            else
            begin
                pos_next = np;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignore_case_reg <= 1'b1;
            mode_reg        <= MODE_IDLE;
            pos_reg         <= '0;
            tbeg_reg        <= '0;
            mant_reg        <= '0;
            fcnt_reg        <= '0;
            sat_reg         <= 1'b0;
            cand_reg        <= '1;
            wlen_reg        <= 4'd0;
            fin_reg         <= 1'b0;
            qcnt_reg        <= 2'd0;
            qlast_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                ignore_case_reg <= cfg_wdata;
            if (accept)
            begin
                // advance the scanner and load the byte's tokens
                mode_reg  <= mode_next;
                pos_reg   <= pos_next;
                tbeg_reg  <= tbeg_next;
                mant_reg  <= mant_next;
                fcnt_reg  <= fcnt_next;
                sat_reg   <= sat_next;
                cand_reg  <= cand_next;
                wlen_reg  <= wlen_next;
                fin_reg   <= fin_next;
                qcnt_reg  <= nres;
                for (int i = 0; i < MAX_RES; i++)
                begin
                    qlast_reg[i] <= (nres == 2'(i + 1));
                end
            end
            else if (pop)
            begin
                qcnt_reg  <= qcnt_reg - 2'd1;
                qlast_reg <= {1'b0, qlast_reg[MAX_RES-1:1]};
            end
        end
    end

    // token payload: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                q_reg[i] <= res[i];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_RES - 1; i++)
            begin
                q_reg[i] <= q_reg[i+1];
            end
        end
    end

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for expression_tokenizer_unit: drives text bytes as requests,
// predicts tokens with an in-bench scanner model and compares every token. Uses etok_pkg.
module tb;
    import etok_pkg::*;

    // scanner modes of the predictor
    typedef enum int {
        S_IDLE, S_INT, S_FRAC, S_WORD, S_IDENT, S_STR, S_AMP, S_BAR,
        S_LT, S_GT, S_GTGT, S_EQ, S_EQQ, S_EQBANG, S_BANG
    } scan_t;

    typedef struct packed {
        logic              last;
        logic [15:0]       len;
        logic [15:0]       start;
        logic              ovf;
        logic [1:0]        fac;
        logic [FRAC_W-1:0] frac;
        logic [VAL_W-1:0]  value;
        logic [KIND_W-1:0] kind;
    } tok_rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tlast;

    expression_tokenizer_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // predictor state
    logic        fold_case;
    scan_t       mode;
    logic [15:0] pos;
    logic [15:0] tok_begin;
    logic [30:0] mant;
    logic [4:0]  nfrac;
    logic        sat;
    logic [5:0]  cands;
    logic [3:0]  wlen;
    logic        finished;

    tok_rec_t    expected_tokens[$];
    int          mismatches = 0;
    int          errors = 0;
    longint      cycles = 0;
    bit          burst_on = 1'b1;
    int          burst_left = 0;
    bit          driving = 1'b0;

    function automatic logic isdig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic isalp(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [7:0] lower(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [1:0] suffix(logic [7:0] c);
        case (lower(c))
            "k": return 2'd1;
            "m": return 2'd2;
            "g": return 2'd3;
            default: return 2'd0;
        endcase
    endfunction

    function automatic string word_text(int k);
        case (k)
            0: return "true";
            1: return "false";
            2: return "undefined";
            3: return "error";
            4: return "is";
            default: return "isnt";
        endcase
    endfunction

    function automatic logic [5:0] word_kind(int k);
        case (k)
            0, 1: return K_INT;
            2: return K_UNDEF;
            3: return K_ERRLIT;
            4: return K_META_EQ;
            default: return K_META_NE;
        endcase
    endfunction

    task automatic push_tok(logic [5:0] k, logic [30:0] v, logic [4:0] f, logic [1:0] fa,
                            logic o, logic [15:0] st, logic [15:0] ln);
        tok_rec_t t;
        t = '{last: 1'b0, len: ln, start: st, ovf: o, fac: fa, frac: f, value: v, kind: k};
        expected_tokens.push_back(t);
    endtask

    task automatic push_kind(logic [5:0] k);
        push_tok(k, '0, '0, '0, 1'b0, '0, '0);
    endtask

    task automatic push_number(bit is_real, logic [1:0] fa);
        push_tok(is_real ? K_REAL : K_INT, mant, is_real ? nfrac : 5'd0, fa, sat, '0, '0);
        mode = S_IDLE;
    endtask

    task automatic push_word(logic [15:0] endp);
        string w;
        for (int k = 0; k < 6; k++)
        begin
            w = word_text(k);
            if (cands[k] && wlen == w.len())
            begin
                push_tok(word_kind(k), (k == 0) ? 31'd1 : 31'd0, '0, '0, 1'b0, '0, '0);
                mode = S_IDLE;
                return;
            end
        end
        push_tok(K_IDENT, '0, '0, '0, 1'b0, tok_begin, endp - tok_begin);
        mode = S_IDLE;
    endtask

    task automatic add_digit(logic [7:0] c);
        longint v;
        v = longint'(mant) * 10 + (c - "0");
        if (v > 64'h7FFF_FFFF)
        begin
            v = 64'h7FFF_FFFF;
            sat = 1'b1;
        end
        mant = v[30:0];
    endtask

    task automatic add_letter(logic [7:0] c);
        logic [7:0] lc;
        string      w;
        lc = fold_case ? lower(c) : c;
        for (int k = 0; k < 6; k++)
        begin
            w = word_text(k);
            if (!(wlen < w.len() && w[wlen] == lc))
                cands[k] = 1'b0;
        end
        if (wlen < 15)
            wlen++;
    endtask

    task automatic scanner_restart();
        mode = S_IDLE;
        pos = '0;
        tok_begin = '0;
        mant = '0;
        nfrac = '0;
        sat = 1'b0;
        cands = '1;
        wlen = '0;
        finished = 1'b0;
    endtask

    // feed a byte to the pending token; used is 1 if the byte was consumed
    task automatic continue_token(logic [7:0] c, logic [15:0] p, output bit used);
        scan_t m;
        m = mode;
        mode = S_IDLE;
        used = 1'b0;
        case (m)
            S_INT:
            begin
                if (isdig(c)) begin add_digit(c); mode = S_INT; used = 1'b1; return; end
                if (c == ".") begin mode = S_FRAC; used = 1'b1; return; end
                if (suffix(c) != 0) begin push_number(0, suffix(c)); used = 1'b1; return; end
                push_number(0, 2'd0);
            end
            S_FRAC:
            begin
                if (isdig(c))
                begin
                    if (nfrac < 31) begin add_digit(c); nfrac++; end
                    mode = S_FRAC;
                    used = 1'b1;
                    return;
                end
                if (suffix(c) != 0) begin push_number(1, suffix(c)); used = 1'b1; return; end
                push_number(1, 2'd0);
            end
            S_WORD:
            begin
                if (isalp(c)) begin add_letter(c); mode = S_WORD; used = 1'b1; return; end
                if (isdig(c) || c == "_") begin mode = S_IDENT; used = 1'b1; return; end
                push_word(p);
            end
            S_IDENT:
            begin
                if (isalp(c) || isdig(c) || c == "_")
                begin
                    mode = S_IDENT;
                    used = 1'b1;
                    return;
                end
                push_tok(K_IDENT, '0, '0, '0, 1'b0, tok_begin, p - tok_begin);
            end
            S_STR:
            begin
                if (c == "\"")
                    push_tok(K_STR, '0, '0, '0, 1'b0, tok_begin, p - tok_begin);
                else
                    mode = S_STR;
                used = 1'b1;
            end
            S_AMP:
            begin
                if (c == "&") begin push_kind(K_LAND); used = 1'b1; return; end
                push_kind(K_AMP);
            end
            S_BAR:
            begin
                if (c == "|") begin push_kind(K_LOR); used = 1'b1; return; end
                push_kind(K_BAR);
            end
            S_LT:
            begin
                if (c == "=") begin push_kind(K_LE); used = 1'b1; return; end
                if (c == "<") begin push_kind(K_SHL); used = 1'b1; return; end
                push_kind(K_LT);
            end
            S_GT:
            begin
                if (c == "=") begin push_kind(K_GE); used = 1'b1; return; end
                if (c == ">") begin mode = S_GTGT; used = 1'b1; return; end
                push_kind(K_GT);
            end
            S_GTGT:
            begin
                if (c == ">") begin push_kind(K_SHRU); used = 1'b1; return; end
                push_kind(K_SHR);
            end
            S_EQ:
            begin
                if (c == "=") begin push_kind(K_EQ); used = 1'b1; return; end
                if (c == "?") begin mode = S_EQQ; used = 1'b1; return; end
                if (c == "!") begin mode = S_EQBANG; used = 1'b1; return; end
                push_kind(K_ASSIGN);
            end
            S_EQQ:
            begin
                if (c == "=") begin push_kind(K_META_EQ); used = 1'b1; return; end
                push_kind(K_ERR);
            end
            S_EQBANG:
            begin
                // the byte after =! is always swallowed
                push_kind(c == "=" ? K_META_NE : K_ERR);
                used = 1'b1;
            end
            S_BANG:
            begin
                if (c == "=") begin push_kind(K_NE); used = 1'b1; return; end
                push_kind(K_NOT);
            end
            default: used = 1'b0;
        endcase
    endtask

    task automatic start_token(logic [7:0] c, logic [15:0] p, logic [15:0] np);
        string ops;
        ops = ".*/%+-~^?:;,[](){}";
        if (c == " " || (c >= 9 && c <= 13))
            return;
        if (isdig(c))
        begin
            mant = '0;
            nfrac = '0;
            sat = 1'b0;
            add_digit(c);
            mode = S_INT;
            return;
        end
        if (isalp(c))
        begin
            tok_begin = p;
            cands = '1;
            wlen = '0;
            add_letter(c);
            mode = S_WORD;
            return;
        end
        if (c == "_") begin tok_begin = p; mode = S_IDENT; return; end
        if (c == "\"") begin tok_begin = np; mode = S_STR; return; end
        for (int i = 0; i < 18; i++)
        begin
            if (ops[i] == c)
            begin
                push_kind(6'(K_DOT + i));
                return;
            end
        end
        case (c)
            "&": mode = S_AMP;
            "|": mode = S_BAR;
            "<": mode = S_LT;
            ">": mode = S_GT;
            "=": mode = S_EQ;
            "!": mode = S_BANG;
            default: push_kind(K_ERR);
        endcase
    endtask

    // close whatever token is pending when the text ends
    task automatic close_pending(logic [15:0] endp);
        case (mode)
            S_INT:    push_number(0, 2'd0);
            S_FRAC:   push_number(1, 2'd0);
            S_WORD:   push_word(endp);
            S_IDENT:  push_tok(K_IDENT, '0, '0, '0, 1'b0, tok_begin, endp - tok_begin);
            S_STR, S_EQQ, S_EQBANG: push_kind(K_ERR);
            S_AMP:    push_kind(K_AMP);
            S_BAR:    push_kind(K_BAR);
            S_LT:     push_kind(K_LT);
            S_GT:     push_kind(K_GT);
            S_GTGT:   push_kind(K_SHR);
            S_EQ:     push_kind(K_ASSIGN);
            S_BANG:   push_kind(K_NOT);
            default:  ;
        endcase
        mode = S_IDLE;
    endtask

    task automatic predict_tokens(logic [7:0] c, logic lst);
        logic [15:0] np;
        int          n0;
        bit          used;
        n0 = expected_tokens.size();
        if (finished)
        begin
            if (lst)
                scanner_restart();
            return;
        end
        np = (pos < 16'hFFFF) ? pos + 16'd1 : pos;
        if (c != 0)
        begin
            continue_token(c, pos, used);
            if (!used)
                start_token(c, pos, np);
        end
        if (c == 0 || lst)
        begin
            close_pending(c == 0 ? pos : np);
            push_kind(K_END);
            scanner_restart();
            if (c == 0 && !lst)
                finished = 1'b1;
        end
        else
            pos = np;
        if (expected_tokens.size() > n0)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endtask

    // drop the request valid if it is still up
    task automatic stop_input();
        if (driving)
        begin
            s_tvalid <= 1'b0;
            driving = 1'b0;
        end
    endtask

    // send one request: bursts with random gaps, predict at acceptance
    task automatic send_byte(logic [7:0] c, logic lst);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                stop_input();
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= lst;
        driving = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_tokens(c, lst);
    endtask

    task automatic send_text(string s, bit with_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], with_last && i == s.len() - 1);
    endtask

    // wait for all tokens, then idle before touching config
    task automatic drain_and_config(logic v);
        stop_input();
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        fold_case = v;
    endtask

    // receiver stall pattern and token checking
    always @(posedge clk)
    begin
        tok_rec_t got;
        tok_rec_t want;
        cycles++;
        if (rst_n)
        begin
            burst_on <= ($urandom_range(0, 15) == 0) ? ~burst_on : burst_on;
            m_tready <= burst_on ? 1'b1 : ($urandom_range(0, 2) == 0);
            if (m_tvalid && m_tready)
            begin
                got = {m_tlast, m_tdata[76:0]};
                if (expected_tokens.size() == 0)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("unexpected token %h", got);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("token mismatch: expected %h got %h", want, got);
                    end
                end
            end
        end
        if (cycles > 400000)
        begin
            $display("FAIL expression_tokenizer_unit");
            $finish;
        end
    end

    task automatic test_operators();
        send_text(". * / % + - ~ ^ ? : ; , [ ] ( ) { } & && | || < <= << > >= >> >>>", 0);
        send_text(" = == =?= =!= ! != =?x =!x @", 1);
        send_text("a=?", 1);
        send_text("b=!", 1);
        send_text("<", 1);
    endtask

    task automatic test_numbers();
        send_text("0 12k 3.25M 7.G 99999999999 1.00000000000000000000000000000000001 ", 0);
        send_text("5g 42", 1);
    endtask

    task automatic test_words();
        send_text("true FALSE Undefined error is isnt x_1 _y abcdefghijklmnopqr t2 ", 0);
        send_text("\"str\xff\" \"open", 1);
    endtask

    task automatic test_text_end();
        send_byte("7", 1'b0);
        send_byte(8'd0, 1'b0);
        send_text("ignored", 0);
        send_byte("z", 1'b1);
        send_byte(8'd0, 1'b1);
        send_byte(8'hff, 1'b1);
    endtask

    task automatic test_random(int count);
        string frags[$];
        string s;
        frags = '{"true", "is", "isnt", "Error", "undefined", "false", "abc", "x9_",
                  "123", "4.56k", "0.1M", "77G", "\"hi\"", "&&", "||", ">>>", ">=",
                  "=?=", "=!=", "!=", "==", "(", ")", "+", "-", "*", "2147483648"};
        for (int i = 0; i < count; )
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                // noise byte, occasionally ending the text
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                i++;
            end
            else
            begin
                s = frags[$urandom_range(0, frags.size() - 1)];
                send_text(s, 0);
                send_byte(" ", $urandom_range(0, 7) == 0);
                i += s.len() + 1;
            end
        end
        send_byte(";", 1'b1);
    endtask

    initial
    begin
        fold_case = 1'b1;
        scanner_restart();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_operators();
        test_numbers();
        drain_and_config(1'b0);
        test_words();
        test_random(15);
        drain_and_config(1'b1);
        test_words();
        test_text_end();
        test_random(15);
        stop_input();
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("PASS expression_tokenizer_unit");
        else
            $display("FAIL expression_tokenizer_unit");
        $finish;
    end
endmodule

// ----- expression_tokenizer_unit.f -----
rtl/etok_pkg.sv
rtl/expression_tokenizer_unit.sv
bench/tb.sv
